// File: rtl/core/rpwf_pkg.sv
// Package for the rotated pixel write formatter.
// Holds shared constants, configuration and pipeline control types.
// No dependencies; every other file in rtl/core uses it.
`timescale 1ns / 1ps
`default_nettype none

package rpwf_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int OFFSET_BITS_DEF = 26;

    localparam int NUM_CHAN    = 3;
    localparam int CHAN_W      = 8;
    localparam int LAYOUT_W    = 8;
    localparam int LEN_W       = 4;
    localparam int MAXV_W      = 15;
    localparam int VM_W        = CHAN_W + MAXV_W;
    localparam int SCALED_W    = VM_W + 1;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 32;
    localparam int WORD_W      = 16;
    localparam int DIM_W       = 13;
    localparam int BPP_W       = 6;
    localparam int ROT_W       = 2;
    localparam int BYTE_SHIFT  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    // Reciprocal of 255 scaled by 2^32, rounded up; exact for dividends below 2^24.
    localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;

    localparam logic [ROT_W-1:0]    ROT_RESET    = 2'd0;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd320;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd240;
    localparam logic [BPP_W-1:0]    BPP_RESET    = 6'd16;
    localparam logic [LAYOUT_W-1:0] RED_RESET    = 8'd91;
    localparam logic [LAYOUT_W-1:0] GREEN_RESET  = 8'd86;
    localparam logic [LAYOUT_W-1:0] BLUE_RESET   = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATION     = 3'd0,
        CFG_LINE_WIDTH   = 3'd1,
        CFG_FRAME_HEIGHT = 3'd2,
        CFG_BPP          = 3'd3,
        CFG_RED_LAYOUT   = 3'd4,
        CFG_GREEN_LAYOUT = 3'd5,
        CFG_BLUE_LAYOUT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [ROT_W-1:0] {
        ROT_NONE = 2'd0,
        ROT_90   = 2'd1,
        ROT_180  = 2'd2,
        ROT_270  = 2'd3
    } t_rot;

    typedef struct packed {
        logic [ROT_W-1:0]                   rotation_mode;
        logic [DIM_W-1:0]                   line_width;
        logic [DIM_W-1:0]                   frame_height;
        logic [BPP_W-1:0]                   pix_bits;
        logic [NUM_CHAN-1:0][LAYOUT_W-1:0]  layout;
    } t_cfg;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

// File: rtl/core/rpwf_cfg_regs.sv
// Configuration register file of the rotated pixel write formatter.
// Decodes the write channel into the seven settings; depends on rpwf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpwf_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rpwf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rpwf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rpwf_pkg::t_cfg                      o_cfg
);

    rpwf_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation_mode  <= rpwf_pkg::ROT_RESET;
            r_cfg.line_width     <= rpwf_pkg::WIDTH_RESET;
            r_cfg.frame_height   <= rpwf_pkg::HEIGHT_RESET;
            r_cfg.pix_bits       <= rpwf_pkg::BPP_RESET;
            r_cfg.layout[0]      <= rpwf_pkg::RED_RESET;
            r_cfg.layout[1]      <= rpwf_pkg::GREEN_RESET;
            r_cfg.layout[2]      <= rpwf_pkg::BLUE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rpwf_pkg::CFG_ROTATION: begin
                    r_cfg.rotation_mode <= i_cfg_data[rpwf_pkg::ROT_W-1:0];
                end
                rpwf_pkg::CFG_LINE_WIDTH: begin
                    r_cfg.line_width <= i_cfg_data[rpwf_pkg::DIM_W-1:0];
                end
                rpwf_pkg::CFG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data[rpwf_pkg::DIM_W-1:0];
                end
                rpwf_pkg::CFG_BPP: begin
                    r_cfg.pix_bits <= i_cfg_data[rpwf_pkg::BPP_W-1:0];
                end
                rpwf_pkg::CFG_RED_LAYOUT: begin
                    r_cfg.layout[0] <= i_cfg_data[rpwf_pkg::LAYOUT_W-1:0];
                end
                rpwf_pkg::CFG_GREEN_LAYOUT: begin
                    r_cfg.layout[1] <= i_cfg_data[rpwf_pkg::LAYOUT_W-1:0];
                end
                rpwf_pkg::CFG_BLUE_LAYOUT: begin
                    r_cfg.layout[2] <= i_cfg_data[rpwf_pkg::LAYOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rpwf_chan_scale.sv
// One color channel lane: rescales an 8-bit value to its configured length
// with rounding and shifts it to its offset, over pipeline stages 1 to 3.
// Depends on rpwf_pkg for widths, the reciprocal constant and control type.
`timescale 1ns / 1ps
`default_nettype none

module rpwf_chan_scale (
    input  wire logic                              i_clk,
    input  wire rpwf_pkg::t_pipe_ctrl              i_ctrl,
    input  wire logic [rpwf_pkg::CHAN_W-1:0]       i_value,
    input  wire logic [rpwf_pkg::LAYOUT_W-1:0]     i_layout,
    output logic [rpwf_pkg::WORD_W-1:0]            o_field
);

    localparam int PROD_W = rpwf_pkg::SCALED_W + rpwf_pkg::RECIP_W;

    logic [rpwf_pkg::LEN_W-1:0]    len;
    logic [rpwf_pkg::LEN_W-1:0]    off;
    logic [rpwf_pkg::WORD_W-1:0]   maxv_full;
    logic [rpwf_pkg::MAXV_W-1:0]   maxv;
    logic [rpwf_pkg::VM_W-1:0]     n_vm;
    logic [rpwf_pkg::VM_W-1:0]     r_vm;
    logic [rpwf_pkg::SCALED_W-1:0] dividend;
    logic [PROD_W-1:0]             recip_prod;
    logic [rpwf_pkg::WORD_W-1:0]   n_quot;
    logic [rpwf_pkg::WORD_W-1:0]   r_quot;
    logic [rpwf_pkg::WORD_W:0]     rounded;
    logic [rpwf_pkg::WORD_W-1:0]   scaled;
    logic [rpwf_pkg::WORD_W-1:0]   n_field;
    logic [rpwf_pkg::WORD_W-1:0]   r_field;

    assign len       = i_layout[rpwf_pkg::LEN_W-1:0];
    assign off       = i_layout[rpwf_pkg::LAYOUT_W-1:rpwf_pkg::LEN_W];
    assign maxv_full = (rpwf_pkg::WORD_W'(1) << len) - rpwf_pkg::WORD_W'(1);
    assign maxv      = maxv_full[rpwf_pkg::MAXV_W-1:0];
    assign n_vm      = rpwf_pkg::VM_W'(i_value) * rpwf_pkg::VM_W'(maxv);

    assign dividend   = {r_vm, 1'b0};
    assign recip_prod = PROD_W'(dividend) * PROD_W'(rpwf_pkg::RECIP_255);
    assign n_quot     = recip_prod[rpwf_pkg::RECIP_SHIFT +: rpwf_pkg::WORD_W];

    assign rounded = (rpwf_pkg::WORD_W+1)'(r_quot) + (rpwf_pkg::WORD_W+1)'(1);
    assign scaled  = rounded[rpwf_pkg::WORD_W:1];
    assign n_field = scaled << off;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_vm <= n_vm;
        end
        if (i_ctrl.en2) begin
            r_quot <= n_quot;
        end
        if (i_ctrl.en3) begin
            r_field <= n_field;
        end
    end

    assign o_field = r_field;

endmodule

`default_nettype wire

// File: rtl/core/rpwf_offset_pipe.sv
// Byte offset datapath: rotation terms, line multiply, sum and bits-per-pixel
// multiply over pipeline stages 1 to 4. Depends on rpwf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpwf_offset_pipe #(
    parameter int COORD_BITS  = rpwf_pkg::COORD_BITS_DEF,
    parameter int OFFSET_BITS = rpwf_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire rpwf_pkg::t_pipe_ctrl   i_ctrl,
    input  wire rpwf_pkg::t_cfg         i_cfg,
    input  wire logic [COORD_BITS-1:0]  i_row,
    input  wire logic [COORD_BITS-1:0]  i_col,
    output logic [OFFSET_BITS-1:0]      o_byte_offset
);

    localparam int TERM_W = ((COORD_BITS > rpwf_pkg::DIM_W) ? COORD_BITS
                                                            : rpwf_pkg::DIM_W) + 1;
    localparam int PROD_W = TERM_W + rpwf_pkg::DIM_W + 1;
    localparam int PIX_W  = OFFSET_BITS + rpwf_pkg::BYTE_SHIFT;
    localparam int EXT_W  = (PROD_W > PIX_W) ? PROD_W : PIX_W;

    logic signed [TERM_W-1:0]          row_s;
    logic signed [TERM_W-1:0]          col_s;
    logic signed [TERM_W-1:0]          w_m1;
    logic signed [TERM_W-1:0]          h_m1;
    logic signed [TERM_W-1:0]          n_add;
    logic signed [TERM_W-1:0]          n_mul;
    logic signed [TERM_W-1:0]          r_add1;
    logic signed [TERM_W-1:0]          r_mul1;
    logic signed [rpwf_pkg::DIM_W:0]   w_s;
    logic signed [PROD_W-1:0]          n_prod;
    logic signed [PROD_W-1:0]          r_prod2;
    logic signed [TERM_W-1:0]          r_add2;
    logic signed [EXT_W-1:0]           sum_ext;
    logic [PIX_W-1:0]                  n_pix;
    logic [PIX_W-1:0]                  r_pix3;
    logic [PIX_W-1:0]                  n_bits;
    logic [OFFSET_BITS-1:0]            r_off4;

    assign row_s = TERM_W'(i_row);
    assign col_s = TERM_W'(i_col);
    assign w_m1  = TERM_W'(i_cfg.line_width) - TERM_W'(1);
    assign h_m1  = TERM_W'(i_cfg.frame_height) - TERM_W'(1);

    always_comb begin
        unique case (rpwf_pkg::t_rot'(i_cfg.rotation_mode))
            rpwf_pkg::ROT_NONE: begin
                n_add = col_s;
                n_mul = row_s;
            end
            rpwf_pkg::ROT_90: begin
                n_add = w_m1 - row_s;
                n_mul = col_s;
            end
            rpwf_pkg::ROT_180: begin
                n_add = w_m1 - col_s;
                n_mul = h_m1 - row_s;
            end
            rpwf_pkg::ROT_270: begin
                n_add = row_s;
                n_mul = h_m1 - col_s;
            end
            default: begin
                n_add = col_s;
                n_mul = row_s;
            end
        endcase
    end

    assign w_s    = $signed({1'b0, i_cfg.line_width});
    assign n_prod = r_mul1 * w_s;

    assign sum_ext = EXT_W'(r_prod2) + EXT_W'(r_add2);
    assign n_pix   = sum_ext[PIX_W-1:0];

    assign n_bits = r_pix3 * PIX_W'(i_cfg.pix_bits);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_add1 <= n_add;
            r_mul1 <= n_mul;
        end
        if (i_ctrl.en2) begin
            r_prod2 <= n_prod;
            r_add2  <= r_add1;
        end
        if (i_ctrl.en3) begin
            r_pix3 <= n_pix;
        end
        if (i_ctrl.en4) begin
            r_off4 <= n_bits[PIX_W-1:rpwf_pkg::BYTE_SHIFT];
        end
    end

    assign o_byte_offset = r_off4;

endmodule

`default_nettype wire

// File: rtl/core/rotated_pixel_write_formatter_unit.sv
// Rotated pixel write formatter: packs an RGB888 pixel into a 16-bit word and
// computes its rotated byte offset in frame memory.
// Usage:
//   Pixel writes enter on the input channel (i_in_valid / o_in_ready) with
//   row, column and 8-bit red, green and blue. Each accepted transfer gives
//   exactly one result transfer on the output channel (o_out_valid /
//   i_out_ready) carrying the byte offset and the packed pixel word.
//   o_out_valid rises once the transfer has passed the four register stages:
//   rotation terms and channel products, the line and reciprocal multiplies,
//   the offset sum and rounding, the bits-per-pixel multiply and word merge.
//   Throughput is one pixel per cycle while the receiver does not stall.
//   When it stalls, results stay in their stages; bubbles are filled first,
//   and o_in_ready drops only once all four stages hold data. Registers are
//   written on the configuration channel (always ready); the user must write
//   them only while no pixel is in flight, which the block does not enforce.
//   Reset empties the pipeline and loads the register defaults: no rotation,
//   320x240, 16 bits per pixel, red 11 bits at 5, green 6 at 5, blue 5 at 0.
// Depends on rpwf_pkg, rpwf_cfg_regs, rpwf_chan_scale and rpwf_offset_pipe.
`timescale 1ns / 1ps
`default_nettype none

module rotated_pixel_write_formatter_unit #(
    parameter int COORD_BITS  = rpwf_pkg::COORD_BITS_DEF,
    parameter int OFFSET_BITS = rpwf_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [COORD_BITS-1:0]            i_row,
    input  wire logic [COORD_BITS-1:0]            i_col,
    input  wire logic [rpwf_pkg::CHAN_W-1:0]      i_red,
    input  wire logic [rpwf_pkg::CHAN_W-1:0]      i_green,
    input  wire logic [rpwf_pkg::CHAN_W-1:0]      i_blue,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [OFFSET_BITS-1:0]                o_byte_offset,
    output logic [rpwf_pkg::WORD_W-1:0]           o_pixel_word,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rpwf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rpwf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    rpwf_pkg::t_cfg       cfg;
    rpwf_pkg::t_pipe_ctrl ctrl;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    logic [rpwf_pkg::NUM_CHAN-1:0][rpwf_pkg::CHAN_W-1:0] chan_in;
    logic [rpwf_pkg::NUM_CHAN-1:0][rpwf_pkg::WORD_W-1:0] chan_field;
    logic [rpwf_pkg::WORD_W-1:0]                         n_word;
    logic [rpwf_pkg::WORD_W-1:0]                         r_word;

    assign ctrl.en4 = !r_v4 || i_out_ready;
    assign ctrl.en3 = !r_v3 || ctrl.en4;
    assign ctrl.en2 = !r_v2 || ctrl.en3;
    assign ctrl.en1 = !r_v1 || ctrl.en2;

    assign o_in_ready  = ctrl.en1;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ctrl.en1) begin
                r_v1 <= i_in_valid;
            end
            if (ctrl.en2) begin
                r_v2 <= r_v1;
            end
            if (ctrl.en3) begin
                r_v3 <= r_v2;
            end
            if (ctrl.en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    rpwf_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rpwf_offset_pipe #(
        .COORD_BITS  (COORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_offset_pipe (
        .i_clk         (i_clk),
        .i_ctrl        (ctrl),
        .i_cfg         (cfg),
        .i_row         (i_row),
        .i_col         (i_col),
        .o_byte_offset (o_byte_offset)
    );

    assign chan_in[0] = i_red;
    assign chan_in[1] = i_green;
    assign chan_in[2] = i_blue;

    for (genvar g = 0; g < rpwf_pkg::NUM_CHAN; g++) begin : g_chan
        rpwf_chan_scale u_chan_scale (
            .i_clk    (i_clk),
            .i_ctrl   (ctrl),
            .i_value  (chan_in[g]),
            .i_layout (cfg.layout[g]),
            .o_field  (chan_field[g])
        );
    end

    assign n_word = chan_field[0] | chan_field[1] | chan_field[2];

    always_ff @(posedge i_clk) begin
        if (ctrl.en4) begin
            r_word <= n_word;
        end
    end

    assign o_pixel_word = r_word;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("Accepted pixel did not enter the first stage.");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("Input stalled while the pipeline had a free stage.");

    a_stage3_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !ctrl.en4) |=> r_v3)
        else $error("Pixel in stage three was lost during a stall.");

    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && i_out_ready && !r_v3) |=> !r_v4)
        else $error("Result shown again after its transfer.");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the rotated pixel write formatter unit.
// Predicts each packed pixel word and rotated byte offset from its own register copy.
// Depends on rpwf_pkg and rotated_pixel_write_formatter_unit.
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_W        = rpwf_pkg::COORD_BITS_DEF;
    localparam int OFFSET_W       = rpwf_pkg::OFFSET_BITS_DEF;
    localparam int PIPE_LATENCY   = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BLOCKS  = 8;
    localparam int BLOCK_PIXELS   = 206;

    typedef struct packed {
        logic [OFFSET_W-1:0]         byte_offset;
        logic [rpwf_pkg::WORD_W-1:0] pixel_word;
    } t_pixel_write;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [COORD_W-1:0]              i_row = '0;
    logic [COORD_W-1:0]              i_col = '0;
    logic [rpwf_pkg::CHAN_W-1:0]     i_red = '0;
    logic [rpwf_pkg::CHAN_W-1:0]     i_green = '0;
    logic [rpwf_pkg::CHAN_W-1:0]     i_blue = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b1;
    logic [OFFSET_W-1:0]             o_byte_offset;
    logic [rpwf_pkg::WORD_W-1:0]     o_pixel_word;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rpwf_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rpwf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    rpwf_pkg::t_rot                  cfg_rot = rpwf_pkg::ROT_NONE;
    logic [rpwf_pkg::DIM_W-1:0]      cfg_width = rpwf_pkg::WIDTH_RESET;
    logic [rpwf_pkg::DIM_W-1:0]      cfg_height = rpwf_pkg::HEIGHT_RESET;
    logic [rpwf_pkg::BPP_W-1:0]      cfg_bpp = rpwf_pkg::BPP_RESET;
    logic [rpwf_pkg::LAYOUT_W-1:0]   cfg_red = rpwf_pkg::RED_RESET;
    logic [rpwf_pkg::LAYOUT_W-1:0]   cfg_green = rpwf_pkg::GREEN_RESET;
    logic [rpwf_pkg::LAYOUT_W-1:0]   cfg_blue = rpwf_pkg::BLUE_RESET;

    t_pixel_write expected_writes[$];
    t_pixel_write oldest_write;
    int           mismatch_count = 0;
    int           pixels_sent = 0;
    int           results_checked = 0;
    int           regs_written = 0;
    int           settings_applied = 0;
    int           idle_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    rotated_pixel_write_formatter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_byte_offset (o_byte_offset),
        .o_pixel_word  (o_pixel_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [rpwf_pkg::WORD_W-1:0] rescale_channel(
            logic [rpwf_pkg::CHAN_W-1:0] value, logic [rpwf_pkg::LAYOUT_W-1:0] layout);
        int unsigned v;
        int unsigned len;
        int unsigned shift;
        int unsigned maxv;
        int unsigned scaled;
        v = value;
        len = layout[3:0];
        shift = layout[7:4];
        maxv = (32'd1 << len) - 32'd1;
        scaled = (((32'd2 * v * maxv) / 32'd255) + 32'd1) / 32'd2;
        return rpwf_pkg::WORD_W'((scaled << shift) & 32'hFFFF);
    endfunction

    function automatic logic [OFFSET_W-1:0] rotated_offset(logic [COORD_W-1:0] row,
                                                           logic [COORD_W-1:0] col);
        longint unsigned w;
        longint unsigned h;
        longint unsigned r;
        longint unsigned c;
        longint unsigned p;
        longint unsigned wrap_mask;
        wrap_mask = (64'd1 << (OFFSET_W + rpwf_pkg::BYTE_SHIFT)) - 64'd1;
        w = cfg_width;
        h = cfg_height;
        r = row;
        c = col;
        case (cfg_rot)
            rpwf_pkg::ROT_NONE: p = c + r * w;
            rpwf_pkg::ROT_90:   p = (w - 1 - r) + c * w;
            rpwf_pkg::ROT_180:  p = (w - 1 - c) + (h - 1 - r) * w;
            default:            p = (h - 1 - c) * w + r;
        endcase
        p = p & wrap_mask;
        p = (p * longint'(cfg_bpp)) & wrap_mask;
        return OFFSET_W'(p >> rpwf_pkg::BYTE_SHIFT);
    endfunction

    function automatic t_pixel_write format_pixel(logic [COORD_W-1:0] row,
                                                  logic [COORD_W-1:0] col,
                                                  logic [rpwf_pkg::CHAN_W-1:0] red,
                                                  logic [rpwf_pkg::CHAN_W-1:0] green,
                                                  logic [rpwf_pkg::CHAN_W-1:0] blue);
        t_pixel_write w;
        w.byte_offset = rotated_offset(row, col);
        w.pixel_word  = rescale_channel(red, cfg_red) | rescale_channel(green, cfg_green)
                      | rescale_channel(blue, cfg_blue);
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                              input logic [rpwf_pkg::CHAN_W-1:0] red,
                              input logic [rpwf_pkg::CHAN_W-1:0] green,
                              input logic [rpwf_pkg::CHAN_W-1:0] blue);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_row      <= row;
        i_col      <= col;
        i_red      <= red;
        i_green    <= green;
        i_blue     <= blue;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_writes.push_back(format_pixel(row, col, red, green, blue));
        pixels_sent++;
    endtask

    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input rpwf_pkg::t_cfg_idx idx,
                             input logic [rpwf_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            rpwf_pkg::CFG_ROTATION:
                cfg_rot = rpwf_pkg::t_rot'(value[rpwf_pkg::ROT_W-1:0]);
            rpwf_pkg::CFG_LINE_WIDTH:   cfg_width = value[rpwf_pkg::DIM_W-1:0];
            rpwf_pkg::CFG_FRAME_HEIGHT: cfg_height = value[rpwf_pkg::DIM_W-1:0];
            rpwf_pkg::CFG_BPP:          cfg_bpp = value[rpwf_pkg::BPP_W-1:0];
            rpwf_pkg::CFG_RED_LAYOUT:   cfg_red = value[rpwf_pkg::LAYOUT_W-1:0];
            rpwf_pkg::CFG_GREEN_LAYOUT: cfg_green = value[rpwf_pkg::LAYOUT_W-1:0];
            rpwf_pkg::CFG_BLUE_LAYOUT:  cfg_blue = value[rpwf_pkg::LAYOUT_W-1:0];
            default: ;
        endcase
        regs_written++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_settings(input rpwf_pkg::t_rot rot, input int unsigned width,
                                  input int unsigned height, input int unsigned bpp,
                                  input int unsigned red_layout,
                                  input int unsigned green_layout,
                                  input int unsigned blue_layout);
        write_reg(rpwf_pkg::CFG_ROTATION, rpwf_pkg::CFG_DATA_W'(rot));
        write_reg(rpwf_pkg::CFG_LINE_WIDTH, rpwf_pkg::CFG_DATA_W'(width));
        write_reg(rpwf_pkg::CFG_FRAME_HEIGHT, rpwf_pkg::CFG_DATA_W'(height));
        write_reg(rpwf_pkg::CFG_BPP, rpwf_pkg::CFG_DATA_W'(bpp));
        write_reg(rpwf_pkg::CFG_RED_LAYOUT, rpwf_pkg::CFG_DATA_W'(red_layout));
        write_reg(rpwf_pkg::CFG_GREEN_LAYOUT, rpwf_pkg::CFG_DATA_W'(green_layout));
        write_reg(rpwf_pkg::CFG_BLUE_LAYOUT, rpwf_pkg::CFG_DATA_W'(blue_layout));
        settings_applied++;
    endtask

    function automatic logic [COORD_W-1:0] coord_below(logic [rpwf_pkg::DIM_W-1:0] dim);
        int unsigned lim;
        lim = (dim == 0) ? 0 : ((dim > (1 << COORD_W)) ? (1 << COORD_W) - 1 : dim - 1);
        return COORD_W'($urandom_range(lim, 0));
    endfunction

    function automatic logic [rpwf_pkg::CHAN_W-1:0] pick_intensity();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return rpwf_pkg::CHAN_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(9))
            0:       return $urandom_range((1 << rpwf_pkg::DIM_W) - 1);
            1:       return $urandom_range(16, 1);
            default: return $urandom_range(4096, 1);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_pixel('0, '0, '0, '0, '0);
        send_pixel('1, '1, '1, '1, '1);
        send_pixel(12'd239, 12'd319, 8'd128, 8'd127, 8'd1);
        send_pixel(12'd1, 12'd0, 8'd254, 8'd3, 8'd200);
        send_pixel(12'hAAA, 12'h555, 8'hAA, 8'h55, 8'hF0);
        send_pixel(12'h555, 12'hAAA, 8'h55, 8'hAA, 8'h0F);
        settle_pipeline();
    endtask

    task automatic test_rotations();
        rpwf_pkg::t_rot rot;
        for (int m = 0; m < 4; m++) begin
            rot = rpwf_pkg::t_rot'(m);
            write_reg(rpwf_pkg::CFG_ROTATION, rpwf_pkg::CFG_DATA_W'(rot));
            send_pixel(12'd5, 12'd7, 8'd10, 8'd20, 8'd30);
            send_pixel(12'd4000, 12'd4095, 8'd255, 8'd0, 8'd99);
            settle_pipeline();
        end
    endtask

    task automatic test_layouts();
        write_settings(rpwf_pkg::ROT_NONE, 320, 240, 16, 8'h08, 8'h0F, 8'h00);
        send_pixel(12'd3, 12'd9, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd3, 12'd9, 8'd77, 8'd1, 8'd200);
        settle_pipeline();
        write_settings(rpwf_pkg::ROT_NONE, 320, 240, 16, 8'hFF, 8'hCB, 8'hF1);
        send_pixel(12'd0, 12'd1, 8'd255, 8'd201, 8'd128);
        send_pixel(12'd0, 12'd1, 8'd1, 8'd13, 8'd127);
        settle_pipeline();
    endtask

    task automatic test_degenerate_geometry();
        write_settings(rpwf_pkg::ROT_180, 0, 0, 0, rpwf_pkg::RED_RESET,
                       rpwf_pkg::GREEN_RESET, rpwf_pkg::BLUE_RESET);
        send_pixel(12'd17, 12'd33, 8'd60, 8'd61, 8'd62);
        settle_pipeline();
        write_settings(rpwf_pkg::ROT_270, 4096, 4096, 32, rpwf_pkg::RED_RESET,
                       rpwf_pkg::GREEN_RESET, rpwf_pkg::BLUE_RESET);
        send_pixel(12'd4095, 12'd0, 8'd9, 8'd8, 8'd7);
        settle_pipeline();
        write_settings(rpwf_pkg::ROT_90, (1 << rpwf_pkg::DIM_W) - 1, 1,
                       (1 << rpwf_pkg::BPP_W) - 1, rpwf_pkg::RED_RESET,
                       rpwf_pkg::GREEN_RESET, rpwf_pkg::BLUE_RESET);
        send_pixel(12'd4095, 12'd4095, 8'd0, 8'd255, 8'd0);
        settle_pipeline();
    endtask

    task automatic apply_random_settings(input int blk);
        int unsigned bpp;
        case (blk)
            1:       write_settings(rpwf_pkg::t_rot'($urandom_range(3)), 4096, 4096, 32,
                                    $urandom_range(255), $urandom_range(255),
                                    $urandom_range(255));
            2:       write_settings(rpwf_pkg::t_rot'($urandom_range(3)), 1, 1, 1,
                                    $urandom_range(255), $urandom_range(255),
                                    $urandom_range(255));
            default: begin
                bpp = ($urandom_range(7) == 0) ? $urandom_range((1 << rpwf_pkg::BPP_W) - 1)
                                               : $urandom_range(32, 1);
                write_settings(rpwf_pkg::t_rot'($urandom_range(3)), pick_dim(), pick_dim(),
                               bpp, $urandom_range(255), $urandom_range(255),
                               $urandom_range(255));
            end
        endcase
    endtask

    task automatic test_random_streams();
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            case (blk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            apply_random_settings(blk);
            repeat (BLOCK_PIXELS) begin
                if ($urandom_range(1) == 0) begin
                    row = coord_below(cfg_height);
                    col = coord_below(cfg_width);
                end else begin
                    row = COORD_W'($urandom);
                    col = COORD_W'($urandom);
                end
                send_pixel(row, col, pick_intensity(), pick_intensity(), pick_intensity());
            end
            settle_pipeline();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_writes.size() == 0) begin
                report_mismatch("result with nothing pending, offset", o_byte_offset, 0);
            end else begin
                oldest_write = expected_writes.pop_front();
                if (o_byte_offset !== oldest_write.byte_offset) begin
                    report_mismatch("byte_offset", o_byte_offset, oldest_write.byte_offset);
                end
                if (o_pixel_word !== oldest_write.pixel_word) begin
                    report_mismatch("pixel_word", o_pixel_word, oldest_write.pixel_word);
                end
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_rotations();
        test_layouts();
        test_degenerate_geometry();
        test_random_streams();
        settle_pipeline();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        $display("covered %0d pixel writes, %0d results checked, %0d mismatches",
                 pixels_sent, results_checked, mismatch_count);
        $display("across all four rotations, %0d register writes, %0d full register sets",
                 regs_written, settings_applied);
        if (mismatch_count == 0 && expected_writes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
